### rtl/core/spfq_pkg.sv
// Shared constants, status and opcode codes, and handshake structs for the
// three-level strict priority FIFO. No dependencies.
`timescale 1ns / 1ps

package spfq_pkg;

    localparam int NUM_LEVELS  = 3;
    localparam int QUEUE_DEPTH = 128;
    localparam int ID_BITS     = 16;

    // port field widths
    localparam int OP_W    = 1;
    localparam int ID_W    = 16;
    localparam int LVL_W   = 2;
    localparam int STAT_W  = 3;
    localparam int WAIT_W  = 8;
    localparam int TOTAL_W = 16;

    // derived storage widths
    localparam int KEEP_W = (ID_BITS < ID_W) ? ID_BITS : ID_W;
    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH = NUM_LEVELS * QUEUE_DEPTH;
    localparam int ADDR_W = $clog2(MEM_DEPTH);
    localparam int SEL_W  = $clog2(NUM_LEVELS);

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // stream packing
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 64;

    localparam logic [OP_W-1:0] OP_ARRIVE = 1'b0;
    localparam logic [OP_W-1:0] OP_SERVE  = 1'b1;

    localparam logic [STAT_W-1:0] ST_ENQUEUED = 3'd0;
    localparam logic [STAT_W-1:0] ST_SERVED   = 3'd1;
    localparam logic [STAT_W-1:0] ST_DROPPED  = 3'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STAT_W-1:0] ST_INVALID  = 3'd4;

    localparam logic [LVL_W-1:0] LVL_NONE = 2'd0;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
    } mem_cmd_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [LVL_W-1:0]   served_level;
        logic [WAIT_W-1:0]  waiting_high;
        logic [WAIT_W-1:0]  waiting_mid;
        logic [WAIT_W-1:0]  waiting_low;
        logic [TOTAL_W-1:0] served_total;
    } item_res_t;

    // advance a ring pointer one slot, wrapping at the queue depth
    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        ring_next = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // flat memory address of a slot in a level's ring
    function automatic logic [ADDR_W-1:0] slot_addr(input logic [SEL_W-1:0] k,
                                                    input logic [PTR_W-1:0] p);
        slot_addr = ADDR_W'(ADDR_W'(k) * ADDR_W'(QUEUE_DEPTH)) + ADDR_W'(p);
    endfunction

endpackage

### rtl/core/spfq_store.sv
// Identifier store: one synchronous single-port memory holding all three
// rings back to back, with registered read data. Depends on spfq_pkg.
`timescale 1ns / 1ps

module spfq_store
    import spfq_pkg::*;
(
    input  logic              aclk,
    input  mem_cmd_t          cmd,
    input  logic [KEEP_W-1:0] wdata,
    output logic [KEEP_W-1:0] rdata
);

    logic [KEEP_W-1:0] mem [0:MEM_DEPTH-1];
    logic [KEEP_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (cmd.we) begin
            mem[cmd.addr] <= wdata;
        end
        // hold read data until the next read
        if (cmd.re) begin
            rdata_reg <= mem[cmd.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/spfq_ctrl.sv
// Ring control: head and tail pointers, fill counts and the served total.
// Decides each item and issues the store access. Depends on spfq_pkg.
`timescale 1ns / 1ps

module spfq_ctrl
    import spfq_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  logic [OP_W-1:0]  opcode,
    input  logic [LVL_W-1:0] level,
    output mem_cmd_t         cmd,
    output item_res_t        res
);

    logic [PTR_W-1:0]   head_reg [NUM_LEVELS];
    logic [PTR_W-1:0]   head_next [NUM_LEVELS];
    logic [PTR_W-1:0]   tail_reg [NUM_LEVELS];
    logic [PTR_W-1:0]   tail_next [NUM_LEVELS];
    logic [CNT_W-1:0]   cnt_reg [NUM_LEVELS];
    logic [CNT_W-1:0]   cnt_next [NUM_LEVELS];
    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] total_next;

    always_comb begin
        logic [SEL_W-1:0] k;
        logic             found;
        head_next  = head_reg;
        tail_next  = tail_reg;
        cnt_next   = cnt_reg;
        total_next = total_reg;
        cmd        = '0;
        res        = '0;
        found      = 1'b0;
        k          = SEL_W'(level - LVL_W'(1));

        if (opcode == OP_ARRIVE) begin
            if (level == LVL_NONE) begin
                res.status = ST_INVALID;
            end else if (cnt_reg[k] == CNT_W'(QUEUE_DEPTH)) begin
                res.status = ST_DROPPED;
            end else begin
                cmd.we       = accept;
                cmd.addr     = slot_addr(k, tail_reg[k]);
                tail_next[k] = ring_next(tail_reg[k]);
                cnt_next[k]  = cnt_reg[k] + CNT_W'(1);
                res.status   = ST_ENQUEUED;
            end
        end else begin
            res.status = ST_EMPTY;
            // strict priority: first non-empty level wins
            for (int i = 0; i < NUM_LEVELS; i++) begin
                if (!found && cnt_reg[i] != '0) begin
                    found            = 1'b1;
                    cmd.re           = accept;
                    cmd.addr         = slot_addr(SEL_W'(i), head_reg[i]);
                    head_next[i]     = ring_next(head_reg[i]);
                    cnt_next[i]      = cnt_reg[i] - CNT_W'(1);
                    res.status       = ST_SERVED;
                    res.served_level = LVL_W'(i + 1);
                    if (total_reg != TOTAL_MAX) begin
                        total_next = total_reg + TOTAL_W'(1);
                    end
                end
            end
        end

        res.waiting_high = WAIT_W'(cnt_next[0]);
        res.waiting_mid  = WAIT_W'(cnt_next[1]);
        res.waiting_low  = WAIT_W'(cnt_next[2]);
        res.served_total = total_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_LEVELS; i++) begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
            total_reg <= '0;
        end else if (accept) begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            cnt_reg   <= cnt_next;
            total_reg <= total_next;
        end
    end

endmodule

### rtl/core/three_level_strict_priority_fifo.sv
// Three-level strict priority FIFO: top level with stream ports.
// Each result word passes through the result stage and the output register to m_.
// Throughput: one word per cycle while m_ is not stalled; each word makes at most
// one access to the single-port identifier store, and pointers and counts update
// at acceptance. Reset (aresetn low, synchronous) empties all levels and clears
// the served total; the store itself is not cleared and needs no clearing pass.
// Depends on spfq_pkg, spfq_ctrl and spfq_store.
`timescale 1ns / 1ps

module three_level_strict_priority_fifo
    import spfq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // input words
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // [0] opcode, [16:1] entry_id, [18:17] level
    // result words
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [2:0] status, [18:3] served_id, [20:19] served_level, [28:21] waiting_high,
    // [36:29] waiting_mid, [44:37] waiting_low, [60:45] served_total
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic [OP_W-1:0]  s_opcode;
    logic [ID_W-1:0]  s_entry_id;
    logic [LVL_W-1:0] s_level;

    logic      in_accept;
    logic      out_load;
    mem_cmd_t  mem_cmd;
    item_res_t ctrl_res;
    logic [KEEP_W-1:0] rd_data;

    // result stage: decision made at acceptance, waiting on store read data
    logic      p_valid_reg;
    item_res_t p_res_reg;

    // output register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [ID_W-1:0]      served_id;

    // unpack the input word
    assign s_opcode   = s_tdata[0];
    assign s_entry_id = s_tdata[16:1];
    assign s_level    = s_tdata[18:17];

    // the output register frees up when empty or being drained this cycle
    assign out_load  = !m_tvalid_reg || m_tready;
    assign s_tready  = !p_valid_reg || out_load;
    assign in_accept = s_tvalid && s_tready;

    spfq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (in_accept),
        .opcode  (s_opcode),
        .level   (s_level),
        .cmd     (mem_cmd),
        .res     (ctrl_res)
    );

    // keep only the configured identifier bits
    spfq_store u_store (
        .aclk  (aclk),
        .cmd   (mem_cmd),
        .wdata (s_entry_id[KEEP_W-1:0]),
        .rdata (rd_data)
    );

    // advance the result stage; hold it while the output register is stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (in_accept) begin
            p_valid_reg <= 1'b1;
        end else if (out_load) begin
            p_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            p_res_reg <= ctrl_res;
        end
    end

    // store read data is valid only for a served word
    assign served_id = (p_res_reg.status == ST_SERVED) ? ID_W'(rd_data) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load && p_valid_reg) begin
            m_tdata_reg <= {3'b000,
                            p_res_reg.served_total,
                            p_res_reg.waiting_low,
                            p_res_reg.waiting_mid,
                            p_res_reg.waiting_high,
                            p_res_reg.served_level,
                            served_id,
                            p_res_reg.status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### tb/sv/tb_spfq_checker.sv
// Result checker for the three-level strict priority FIFO: watches both stream channels,
// predicts each result word from the accepted input words and compares field by field.
// Depends on spfq_pkg.
`timescale 1ns / 1ps

module tb_spfq_checker
    import spfq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    output int                   mismatches,
    output int                   results_owed
);

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [ID_W-1:0]    served_id;
        logic [LVL_W-1:0]   served_level;
        logic [WAIT_W-1:0]  waiting_high;
        logic [WAIT_W-1:0]  waiting_mid;
        logic [WAIT_W-1:0]  waiting_low;
        logic [TOTAL_W-1:0] served_total;
    } queue_result_t;

    // shadow copy of the three rings and the served total
    logic [ID_W-1:0]    id_ring [NUM_LEVELS][QUEUE_DEPTH];
    int                 rd_slot [NUM_LEVELS];
    int                 wr_slot [NUM_LEVELS];
    int                 fill    [NUM_LEVELS];
    logic [TOTAL_W-1:0] total_served;

    queue_result_t owed_results[$];
    queue_result_t want, got;
    int            errors = 0;

    function automatic queue_result_t queue_outcome(input logic [OP_W-1:0]  op,
                                                    input logic [ID_W-1:0]  id,
                                                    input logic [LVL_W-1:0] lvl);
        queue_result_t r;
        int            k;
        logic          hit;
        r   = '0;
        hit = 1'b0;
        if (op == OP_ARRIVE) begin
            if (lvl == LVL_NONE) begin
                r.status = ST_INVALID;
            end else begin
                k = int'(lvl) - 1;
                if (fill[k] >= QUEUE_DEPTH) begin
                    r.status = ST_DROPPED;
                end else begin
                    id_ring[k][wr_slot[k]] = id;
                    wr_slot[k] = (wr_slot[k] + 1) % QUEUE_DEPTH;
                    fill[k]++;
                    r.status = ST_ENQUEUED;
                end
            end
        end else begin
            r.status = ST_EMPTY;
            for (k = 0; k < NUM_LEVELS; k++) begin
                if (!hit && fill[k] != 0) begin
                    hit            = 1'b1;
                    r.served_id    = id_ring[k][rd_slot[k]];
                    r.served_level = LVL_W'(k + 1);
                    rd_slot[k]     = (rd_slot[k] + 1) % QUEUE_DEPTH;
                    fill[k]--;
                    if (total_served != TOTAL_MAX) total_served++;
                    r.status = ST_SERVED;
                end
            end
        end
        r.waiting_high = WAIT_W'(fill[0]);
        r.waiting_mid  = WAIT_W'(fill[1]);
        r.waiting_low  = WAIT_W'(fill[2]);
        r.served_total = total_served;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] exp_val,
                                 input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_val, act_val);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_LEVELS; k++) begin
                rd_slot[k] = 0;
                wr_slot[k] = 0;
                fill[k]    = 0;
            end
            total_served = '0;
            owed_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (owed_results.size() == 0) begin
                    $error("result word with no prediction waiting: %0h", m_tdata);
                    errors++;
                end else begin
                    want = owed_results.pop_front();
                    got.status       = m_tdata[2:0];
                    got.served_id    = m_tdata[18:3];
                    got.served_level = m_tdata[20:19];
                    got.waiting_high = m_tdata[28:21];
                    got.waiting_mid  = m_tdata[36:29];
                    got.waiting_low  = m_tdata[44:37];
                    got.served_total = m_tdata[60:45];
                    compare_field("status", 32'(want.status), 32'(got.status));
                    compare_field("served_id", 32'(want.served_id), 32'(got.served_id));
                    compare_field("served_level", 32'(want.served_level),
                                  32'(got.served_level));
                    compare_field("waiting_high", 32'(want.waiting_high),
                                  32'(got.waiting_high));
                    compare_field("waiting_mid", 32'(want.waiting_mid),
                                  32'(got.waiting_mid));
                    compare_field("waiting_low", 32'(want.waiting_low),
                                  32'(got.waiting_low));
                    compare_field("served_total", 32'(want.served_total),
                                  32'(got.served_total));
                end
            end
            if (s_tvalid && s_tready)
                owed_results.push_back(queue_outcome(s_tdata[0], s_tdata[16:1],
                                                     s_tdata[18:17]));
        end
        mismatches   <= errors;
        results_owed <= owed_results.size();
    end

endmodule

### tb/sv/tb_three_level_strict_priority_fifo.sv
// Testbench top for the three-level strict priority FIFO: clock, reset, input words and
// result back-pressure; the verdict comes from tb_spfq_checker.
// Depends on spfq_pkg, tb_spfq_checker and three_level_strict_priority_fifo.
`timescale 1ns / 1ps

module tb_three_level_strict_priority_fifo;
    import spfq_pkg::*;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tready = 1'b0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic [M_TDATA_W-1:0] m_tdata;

    int mismatches;
    int results_owed;

    // random idle bursts on both sides while this is set
    bit idle_on    = 1'b1;
    int stall_left = 0;

    // share of arrive words in each random chunk, in percent
    int arrive_pct [4] = '{70, 40, 60, 30};

    three_level_strict_priority_fifo dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    tb_spfq_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .mismatches   (mismatches),
        .results_owed (results_owed)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Result side: stall in random bursts, otherwise take every word.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 3) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Present one input word and hold it until the handshake takes it. Valid stays high
    // on return, so the next call can follow back to back; an optional idle burst drops
    // it first.
    task automatic send_word(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                             input logic [LVL_W-1:0] lvl);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({lvl, id, op});
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drop valid and hold off until every predicted result word has been checked.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_owed != 0) @(posedge aclk);
    endtask

    initial begin
        int lv;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: serve on empty, invalid level, two arrives per level with edge ids
        send_word(OP_SERVE, 16'hFFFF, 2'd3);
        send_word(OP_ARRIVE, 16'hFFFF, LVL_NONE);
        send_word(OP_ARRIVE, 16'h0000, LVL_NONE);
        send_word(OP_ARRIVE, 16'hA5A5, 2'd3);
        send_word(OP_ARRIVE, 16'hFFFF, 2'd2);
        send_word(OP_ARRIVE, 16'h0000, 2'd1);
        send_word(OP_ARRIVE, 16'h5A5A, 2'd1);
        send_word(OP_ARRIVE, 16'h0001, 2'd3);
        send_word(OP_ARRIVE, 16'h8000, 2'd2);
        // strict priority: both level 1, then both level 2, then both level 3, then empty
        repeat (7) send_word(OP_SERVE, 16'($urandom), 2'($urandom));
        send_word(OP_SERVE, 16'hFFFF, LVL_NONE);

        // fill the middle level past full so the extra words drop, then drain all of it
        repeat (QUEUE_DEPTH + 2) send_word(OP_ARRIVE, 16'($urandom), 2'd2);
        repeat (QUEUE_DEPTH + 3)
            send_word(OP_SERVE, 16'($urandom), 2'($urandom));

        // random chunks, alternating between filling and draining
        for (int chunk = 0; chunk < 4; chunk++) begin
            if (chunk == 2) wait_drained();
            repeat (25) begin
                if ($urandom_range(0, 99) < arrive_pct[chunk]) begin
                    lv = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, NUM_LEVELS);
                    send_word(OP_ARRIVE, 16'($urandom), LVL_W'(lv));
                end else begin
                    send_word(OP_SERVE, 16'($urandom), 2'($urandom));
                end
            end
        end

        // no idling from here: back to back arrive and serve pairs
        idle_on = 1'b0;
        repeat (15) begin
            send_word(OP_ARRIVE, 16'($urandom), LVL_W'($urandom_range(1, NUM_LEVELS)));
            send_word(OP_SERVE, 16'($urandom), 2'($urandom));
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && results_owed == 0) begin
            $display("tb_three_level_strict_priority_fifo OK");
        end else begin
            $display("tb_three_level_strict_priority_fifo NOT OK");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("tb_three_level_strict_priority_fifo NOT OK");
        $finish;
    end

endmodule
